// File: rtl/core/fpa_pkg.sv
package fpa_pkg;

  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned DATA_W        = 32;
  // Quotient bits kept by the divider: one above the word so that the
  // most negative result is exact and anything larger is seen as overflow.
  localparam int unsigned QUO_W         = DATA_W + 1;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_LT      = 4'd5,
    OP_GE      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  // What the back end still has to do with a request.
  typedef enum logic [1:0] {
    CLS_DONE = 2'd0,
    CLS_MUL  = 2'd1,
    CLS_DIV  = 2'd2
  } cls_e;

  typedef struct packed {
    cls_e              cls;
    logic              neg;
    logic              b_zero;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] value;
    logic              cmp;
    status_e           st;
  } req_t;

  localparam logic [DATA_W-1:0] MAX_WORD = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_WORD = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// File: rtl/core/fpa_front.sv
module fpa_front #(
  parameter int unsigned FractionBits = fpa_pkg::FRACTION_BITS
) (
  input  logic [3:0]         op_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output fpa_pkg::req_t      req_o
);
  import fpa_pkg::*;

  logic signed [DATA_W:0]              ax;
  logic signed [DATA_W:0]              addend;
  logic signed [DATA_W:0]              sum;
  logic                                sum_ovf;
  logic [DATA_W+FractionBits-1:0]      shl;
  logic                                shl_ovf;
  logic                                lt;
  logic                                eq;

  always_comb begin
    ax = {operand_a_i[31], operand_a_i};
    case (op_e'(op_i))
      OP_SUB:  addend = -{operand_b_i[31], operand_b_i};
      OP_INC:  addend = (DATA_W+1)'(1);
      OP_DEC:  addend = -(DATA_W+1)'(1);
      default: addend = {operand_b_i[31], operand_b_i};
    endcase
    sum     = ax + addend;
    sum_ovf = sum[DATA_W] ^ sum[DATA_W-1];

    shl     = {operand_a_i, {FractionBits{1'b0}}};
    shl_ovf = !((&shl[DATA_W+FractionBits-1:DATA_W-1]) ||
                !(|shl[DATA_W+FractionBits-1:DATA_W-1]));

    lt = operand_a_i < operand_b_i;
    eq = operand_a_i == operand_b_i;

    req_o.cls    = CLS_DONE;
    req_o.neg    = operand_a_i[31] ^ operand_b_i[31];
    req_o.b_zero = operand_b_i == '0;
    req_o.mag_a  = operand_a_i[31] ? DATA_W'(-operand_a_i) : operand_a_i;
    req_o.mag_b  = operand_b_i[31] ? DATA_W'(-operand_b_i) : operand_b_i;
    req_o.value  = '0;
    req_o.cmp    = 1'b0;
    req_o.st     = ST_OK;

    unique case (op_e'(op_i))
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (sum_ovf) begin
          req_o.value = sum[DATA_W] ? MIN_WORD : MAX_WORD;
          req_o.st    = ST_OVF;
        end else begin
          req_o.value = sum[DATA_W-1:0];
        end
      end
      OP_MUL:  req_o.cls = CLS_MUL;
      OP_DIV:  req_o.cls = CLS_DIV;
      OP_GT:   req_o.cmp = !lt && !eq;
      OP_LT:   req_o.cmp = lt;
      OP_GE:   req_o.cmp = !lt;
      OP_LE:   req_o.cmp = lt || eq;
      OP_EQ:   req_o.cmp = eq;
      OP_NE:   req_o.cmp = !eq;
      OP_MIN:  req_o.value = lt ? operand_a_i : operand_b_i;
      OP_MAX:  req_o.value = (!lt && !eq) ? operand_a_i : operand_b_i;
      OP_TOINT: req_o.value = DATA_W'(operand_a_i >>> FractionBits);
      OP_FROMINT: begin
        if (shl_ovf) begin
          req_o.value = operand_a_i[31] ? MIN_WORD : MAX_WORD;
          req_o.st    = ST_OVF;
        end else begin
          req_o.value = shl[DATA_W-1:0];
        end
      end
    endcase
  end

endmodule

// File: rtl/core/fpa_queue.sv
module fpa_queue #(
  parameter int unsigned Depth = fpa_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fpa_pkg::req_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output fpa_pkg::req_t pop_data_o
);
  import fpa_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = count_q == CntW'(Depth);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/fpa_back.sv
module fpa_back #(
  parameter int unsigned FractionBits = fpa_pkg::FRACTION_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  fpa_pkg::req_t req_i,
  output logic          req_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   value_o,
  output logic          compare_true_o,
  output logic [1:0]    status_o
);
  import fpa_pkg::*;

  // Dividend 2*|a|*2^F + |b| and divisor 2*|b|.
  localparam int unsigned NumW = DATA_W + FractionBits + 2;
  localparam int unsigned DenW = DATA_W + 1;
  localparam int unsigned RndW = 2 * DATA_W + 1;

  typedef struct packed {
    req_t                  req;
    logic [2*DATA_W-1:0]   prod;
    logic [NumW-1:0]       num;
    logic [DenW-1:0]       den;
    logic [DenW-1:0]       rem;
    logic [QUO_W-1:0]      quo;
    logic                  big;
  } stage_t;

  stage_t            pipe_q [QUO_W+1];
  logic              valid_q [QUO_W+1];
  logic              advance;
  logic [DATA_W-1:0] value_q, value_d;
  logic              cmp_q, cmp_d;
  status_e           st_q, st_d;
  logic              out_valid_q;

  stage_t            s0_d;
  logic [DATA_W+FractionBits-1:0] scaled_a;
  logic [NumW-DenW-1:0]           num_hi;

  // The whole pipeline moves together whenever the output register frees.
  assign advance   = !out_valid_q || out_ready_i;
  assign req_pop_o = advance && req_valid_i;

  always_comb begin
    scaled_a  = {req_i.mag_a, {FractionBits{1'b0}}};
    s0_d.req  = req_i;
    s0_d.prod = {{DATA_W{1'b0}}, req_i.mag_a} * {{DATA_W{1'b0}}, req_i.mag_b};
    s0_d.num  = {1'b0, scaled_a, 1'b0} + NumW'(req_i.mag_b);
    s0_d.den  = {req_i.mag_b, 1'b0};
    num_hi    = s0_d.num[NumW-1:DenW];
    // A quotient of 2^33 or more would not fit the divider: flag it as overflow.
    s0_d.big  = DenW'(num_hi) >= s0_d.den;
    s0_d.rem  = DenW'(num_hi);
    s0_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (advance) begin
      valid_q[0] <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pipe_q[0] <= s0_d;
    end
  end

  // One restoring division step per stage; the first stage also rounds the product.
  for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
    localparam int unsigned Bit = QUO_W - j;
    stage_t            st_d_s;
    logic [DenW:0]     trial;
    logic [RndW-1:0]   rnd;
    logic [RndW-1:0]   mq;

    always_comb begin
      st_d_s = pipe_q[j-1];
      trial  = {pipe_q[j-1].rem, pipe_q[j-1].num[Bit]};
      if (trial >= {1'b0, pipe_q[j-1].den}) begin
        st_d_s.rem      = DenW'(trial - {1'b0, pipe_q[j-1].den});
        st_d_s.quo[Bit] = 1'b1;
      end else begin
        st_d_s.rem = DenW'(trial);
      end
      rnd = {1'b0, pipe_q[j-1].prod} + (RndW'(1) << (FractionBits - 1));
      mq  = rnd >> FractionBits;
      if (j == 1 && pipe_q[j-1].req.cls == CLS_MUL) begin
        if (pipe_q[j-1].req.neg && mq > RndW'(MIN_WORD)) begin
          st_d_s.req.value = MIN_WORD;
          st_d_s.req.st    = ST_OVF;
        end else if (!pipe_q[j-1].req.neg && mq > RndW'(MAX_WORD)) begin
          st_d_s.req.value = MAX_WORD;
          st_d_s.req.st    = ST_OVF;
        end else begin
          st_d_s.req.value = pipe_q[j-1].req.neg ? DATA_W'(-mq[DATA_W-1:0])
                                                 : mq[DATA_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (advance) begin
        valid_q[j] <= valid_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        pipe_q[j] <= st_d_s;
      end
    end
  end

  always_comb begin
    value_d = pipe_q[QUO_W].req.value;
    cmp_d   = pipe_q[QUO_W].req.cmp;
    st_d    = pipe_q[QUO_W].req.st;
    if (pipe_q[QUO_W].req.cls == CLS_DIV) begin
      if (pipe_q[QUO_W].req.b_zero) begin
        value_d = '0;
        st_d    = ST_DIV0;
      end else if (pipe_q[QUO_W].req.neg) begin
        if (pipe_q[QUO_W].big || pipe_q[QUO_W].quo > QUO_W'(MIN_WORD)) begin
          value_d = MIN_WORD;
          st_d    = ST_OVF;
        end else begin
          value_d = DATA_W'(-pipe_q[QUO_W].quo[DATA_W-1:0]);
        end
      end else if (pipe_q[QUO_W].big || pipe_q[QUO_W].quo > QUO_W'(MAX_WORD)) begin
        value_d = MAX_WORD;
        st_d    = ST_OVF;
      end else begin
        value_d = pipe_q[QUO_W].quo[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= valid_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      value_q <= value_d;
      cmp_q   <= cmp_d;
      st_q    <= st_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign compare_true_o = cmp_q;
  assign status_o       = st_q;

endmodule

// File: rtl/core/fixed_point_q24_8_alu.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    op_i, operand_a_i, operand_b_i
// out       output     out_valid_o / out_ready_i  value_o, compare_true_o, status_o
//
// One request is taken per cycle while in_ready_o is high, and every request gives one
// result; the depth of the back end is set by the 33 quotient bits of the
// pipelined divider, one bit per stage, and every opcode passes through every stage.
// Reset (rst_ni low, asynchronous) empties the queue and clears every valid bit.
// A stall at the output freezes the whole back-end pipeline; the two-entry queue keeps
// taking requests until it is full, then in_ready_o drops.
module fixed_point_q24_8_alu #(
  parameter int unsigned FractionBits = fpa_pkg::FRACTION_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         op_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic               compare_true_o,
  output logic [1:0]         status_o
);
  import fpa_pkg::*;

  req_t front_req;
  req_t queue_req;
  logic queue_full;
  logic queue_empty;
  logic queue_pop;
  logic [31:0] value_raw;

  // The front end decodes the opcode, finishes every operation but multiply and
  // divide, and prepares operand magnitudes and the result sign for those two.
  fpa_front #(
    .FractionBits(FractionBits)
  ) u_front (
    .op_i       (op_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .req_o      (front_req)
  );

  // The queue decouples the front end from the back-end pipeline.
  fpa_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_data_i(front_req),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .empty_o    (queue_empty),
    .pop_data_o (queue_req)
  );

  assign in_ready_o = !queue_full;

  // The back end holds the multiplier, the rounding of the product and the
  // divider stages, and ends in the output register.
  fpa_back #(
    .FractionBits(FractionBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (!queue_empty),
    .req_i         (queue_req),
    .req_pop_o     (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_raw),
    .compare_true_o(compare_true_o),
    .status_o      (status_o)
  );

  assign value_o = value_raw;

endmodule

// File: tb/tb_top.sv
module tb_top;
  import fpa_pkg::*;

  // LATENCY is the latency with the output never stalled; the drain after the
  // last result is sized from it.
  localparam int unsigned LATENCY   = 35;
  localparam int unsigned WDOG_MAX  = 4000;
  localparam int unsigned N_RANDOM  = 1700;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [3:0]         op_i;
  logic signed [31:0] operand_a_i;
  logic signed [31:0] operand_b_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] value_o;
  logic               compare_true_o;
  logic [1:0]         status_o;

  fixed_point_q24_8_alu DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .compare_true_o(compare_true_o),
    .status_o      (status_o)
  );

  // One expected result: the raw word, the compare flag and the status code.
  typedef struct {
    logic [31:0] value;
    logic        cmp;
    status_e     st;
  } alu_result_t;

  // A row of the directed table. Where has_exp is set the result is typed in
  // by hand and also cross-checked against the predictor.
  typedef struct {
    op_e         op;
    logic [31:0] a;
    logic [31:0] b;
    bit          has_exp;
    alu_result_t exp;
  } directed_row_t;

  alu_result_t pending_results[$];

  int unsigned errors;
  int unsigned mismatches;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned idle_cycles;
  int unsigned op_seen[16];
  bit          stim_done;
  bit          long_hold;    // set by the sender to ask the receiver for a long stall
  bit          calm;         // no random idling on either side while set

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Saturate a 64-bit exact result to the signed 32-bit word. The overflow
  // flag is raised whenever the bound is taken.
  function automatic void clamp_word(input longint exact, output logic [31:0] w,
                                     inout status_e st);
    if (exact > 64'sd2147483647) begin
      w  = MAX_WORD;
      st = ST_OVF;
    end else if (exact < -64'sd2147483648) begin
      w  = MIN_WORD;
      st = ST_OVF;
    end else begin
      w = exact[31:0];
    end
  endfunction

  // Works out the result that the ALU must give for one request. Everything
  // is done in 64-bit exact arithmetic, with rounding half away from zero for
  // multiply and divide.
  function automatic alu_result_t alu_predict(op_e op, logic [31:0] a_raw,
                                              logic [31:0] b_raw);
    alu_result_t r;
    longint      a;
    longint      b;
    longint      ex;
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned q;
    bit          neg;
    a       = longint'($signed(a_raw));
    b       = longint'($signed(b_raw));
    ma      = (a < 0) ? longint'(-a) : a;
    mb      = (b < 0) ? longint'(-b) : b;
    neg     = (a < 0) != (b < 0);
    r.value = '0;
    r.cmp   = 1'b0;
    r.st    = ST_OK;
    case (op)
      OP_ADD: clamp_word(a + b, r.value, r.st);
      OP_SUB: clamp_word(a - b, r.value, r.st);
      OP_MUL: begin
        q  = (ma * mb + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        ex = neg ? -longint'(q) : longint'(q);
        clamp_word(ex, r.value, r.st);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.st = ST_DIV0;
        end else begin
          q  = (2 * (ma << FRACTION_BITS) + mb) / (2 * mb);
          ex = neg ? -longint'(q) : longint'(q);
          clamp_word(ex, r.value, r.st);
        end
      end
      OP_GT:  r.cmp = a > b;
      OP_LT:  r.cmp = a < b;
      OP_GE:  r.cmp = a >= b;
      OP_LE:  r.cmp = a <= b;
      OP_EQ:  r.cmp = a == b;
      OP_NE:  r.cmp = a != b;
      // On a tie both of these return operand b.
      OP_MIN: r.value = (a < b) ? a_raw : b_raw;
      OP_MAX: r.value = (a > b) ? a_raw : b_raw;
      OP_INC: clamp_word(a + 1, r.value, r.st);
      OP_DEC: clamp_word(a - 1, r.value, r.st);
      OP_TOINT: begin
        ex      = a >>> FRACTION_BITS;
        r.value = ex[31:0];
      end
      default: clamp_word(a * (64'sd1 <<< FRACTION_BITS), r.value, r.st);
    endcase
    return r;
  endfunction

  // Offers one request and holds it until it is accepted. Inputs move at the
  // falling edge only; valid stays high across back-to-back requests.
  task automatic send_request(op_e op, logic [31:0] a, logic [31:0] b);
    @(negedge clk_i);
    if (!calm) begin
      while ($urandom_range(99) < 14) begin
        in_valid_i  <= 1'b0;
        operand_a_i <= $urandom;
        operand_b_i <= $urandom;
        @(negedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(alu_predict(op, a, b));
    op_seen[op]++;
    n_sent++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Picks an operand with a bias towards the interesting corners.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return MAX_WORD - $urandom_range(2);
      1:       return MIN_WORD + $urandom_range(2);
      2:       return $urandom_range(3) - 1;                    // -1 .. 2
      3:       return 32'($signed($urandom_range(65535)) - 32768);
      4:       return {{20{$urandom_range(1) == 1}}, 12'($urandom)};
      5:       return 32'(1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  directed_row_t directed_table[$];

  function automatic directed_row_t row(op_e op, logic [31:0] a, logic [31:0] b,
                                        bit has_exp = 1'b0, logic [31:0] v = '0,
                                        logic c = 1'b0, status_e st = ST_OK);
    directed_row_t d;
    d.op        = op;
    d.a         = a;
    d.b         = b;
    d.has_exp   = has_exp;
    d.exp.value = v;
    d.exp.cmp   = c;
    d.exp.st    = st;
    return d;
  endfunction

  // Stimulus: directed table first, then a long random run with a stretch of
  // back pressure and a pause that lets the pipeline drain completely.
  initial begin
    alu_result_t chk;
    op_e         op;
    errors      = 0;
    n_sent      = 0;
    stim_done   = 1'b0;
    long_hold   = 1'b0;
    calm        = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = OP_ADD;
    operand_a_i = '0;
    operand_b_i = '0;
    rst_ni      = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_table.push_back(row(OP_ADD, MAX_WORD, 32'd1, 1, MAX_WORD, 0, ST_OVF));
    directed_table.push_back(row(OP_SUB, MIN_WORD, 32'd1, 1, MIN_WORD, 0, ST_OVF));
    directed_table.push_back(row(OP_ADD, 32'h0000_0180, 32'h0000_0080, 1, 32'h200));
    directed_table.push_back(row(OP_MUL, MAX_WORD, MAX_WORD, 1, MAX_WORD, 0, ST_OVF));
    directed_table.push_back(row(OP_MUL, MIN_WORD, MAX_WORD, 1, MIN_WORD, 0, ST_OVF));
    // Half an LSB rounds away from zero on both signs.
    directed_table.push_back(row(OP_MUL, 32'h0000_0001, 32'h0000_0080, 1, 32'd1));
    directed_table.push_back(row(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080, 1, 32'hFFFF_FFFF));
    directed_table.push_back(row(OP_MUL, MIN_WORD, MIN_WORD));
    directed_table.push_back(row(OP_DIV, 32'h0000_0100, 32'd0, 1, 32'd0, 0, ST_DIV0));
    directed_table.push_back(row(OP_DIV, MIN_WORD, 32'd0, 1, 32'd0, 0, ST_DIV0));
    directed_table.push_back(row(OP_DIV, MIN_WORD, 32'h0000_0100, 1, MIN_WORD));
    directed_table.push_back(row(OP_DIV, MIN_WORD, 32'hFFFF_FF00, 1, MAX_WORD, 0, ST_OVF));
    directed_table.push_back(row(OP_DIV, 32'h0000_0001, 32'h0000_0200));
    directed_table.push_back(row(OP_DIV, 32'hFFFF_FFFF, MIN_WORD));
    directed_table.push_back(row(OP_GT, MAX_WORD, MIN_WORD, 1, 32'd0, 1));
    directed_table.push_back(row(OP_LT, MAX_WORD, MIN_WORD, 1, 32'd0, 0));
    directed_table.push_back(row(OP_GE, 32'd5, 32'd5, 1, 32'd0, 1));
    directed_table.push_back(row(OP_LE, MIN_WORD, MIN_WORD, 1, 32'd0, 1));
    directed_table.push_back(row(OP_EQ, 32'd7, 32'd7, 1, 32'd0, 1));
    directed_table.push_back(row(OP_NE, 32'd7, 32'd7, 1, 32'd0, 0));
    // Equal operands: min and max both hand back operand b.
    directed_table.push_back(row(OP_MIN, 32'd9, 32'd9, 1, 32'd9));
    directed_table.push_back(row(OP_MAX, MIN_WORD, MAX_WORD, 1, MAX_WORD));
    directed_table.push_back(row(OP_INC, MAX_WORD, 32'd0, 1, MAX_WORD, 0, ST_OVF));
    directed_table.push_back(row(OP_DEC, MIN_WORD, 32'd0, 1, MIN_WORD, 0, ST_OVF));
    directed_table.push_back(row(OP_TOINT, MIN_WORD, 32'd0, 1, 32'hFF80_0000));
    directed_table.push_back(row(OP_TOINT, 32'hFFFF_FFFF, 32'd0, 1, 32'hFFFF_FFFF));
    directed_table.push_back(row(OP_FROMINT, 32'h0080_0000, 32'd0, 1, MAX_WORD, 0, ST_OVF));
    directed_table.push_back(row(OP_FROMINT, 32'hFF80_0000, 32'd0, 1, MIN_WORD));

    foreach (directed_table[i]) begin
      if (directed_table[i].has_exp) begin
        chk = alu_predict(directed_table[i].op, directed_table[i].a, directed_table[i].b);
        if (chk.value !== directed_table[i].exp.value ||
            chk.cmp !== directed_table[i].exp.cmp ||
            chk.st !== directed_table[i].exp.st) begin
          errors++;
          $display("table row %0d: predictor disagrees with typed result", i);
        end
      end
      send_request(directed_table[i].op, directed_table[i].a, directed_table[i].b);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      // A calm stretch with no idling on either side.
      if (i == 300) calm = 1'b1;
      if (i == 500) calm = 1'b0;
      // Long receiver stall while requests keep coming, so the queue fills.
      if (i == 800) long_hold = 1'b1;
      // Pause until every request in flight has come back.
      if (i == 1200) begin
        release_input();
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      op = op_e'($urandom_range(15));
      send_request(op, pick_operand(), pick_operand());
    end
    release_input();
    stim_done = 1'b1;
  end

  // Receiver: random back pressure, plus one long hold when asked for.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (200) @(negedge clk_i);
        long_hold   = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    alu_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h cmp %b status %0d",
                   value_o, compare_true_o, status_o);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (value_o !== want.value || compare_true_o !== want.cmp ||
            status_o !== want.st) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%0d got %h/%b/%0d",
                     want.value, want.cmp, want.st,
                     value_o, compare_true_o, status_o);
        end
      end
    end
  end

  // Watchdog: cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int unsigned ops_hit;
    mismatches  = 0;
    n_checked   = 0;
    idle_cycles = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    fork
      begin
        wait (stim_done);
        while (pending_results.size() != 0) @(posedge clk_i);
        repeat (4 * LATENCY) @(posedge clk_i);
      end
      begin
        @(posedge rst_ni);
        wait (idle_cycles >= WDOG_MAX);
        $display("watchdog: no progress for %0d cycles", WDOG_MAX);
        $display("fixed_point_q24_8_alu test failed");
        $finish;
      end
    join_any
    ops_hit = 0;
    foreach (op_seen[i]) if (op_seen[i] != 0) ops_hit++;
    $display("%0d requests sent, %0d results checked, %0d of 16 opcodes exercised",
             n_sent, n_checked, ops_hit);
    $display("included saturation, divide by zero, rounding ties and a full-queue stall");
    if (errors == 0 && pending_results.size() == 0)
      $display("fixed_point_q24_8_alu test passed");
    else
      $display("fixed_point_q24_8_alu test failed");
    $finish;
  end

endmodule
